// ----- rtl/abm_pkg.sv -----
`timescale 1ns / 1ps
package abm_pkg;

   localparam int DATA_W     = 32;
   localparam int SUM_W      = DATA_W + 3;
   localparam int ADDR_W_DEF = 32;
   localparam int CSR_IDX_W  = 1;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] REQ_ALLOC   = 2'd0;
   localparam logic [1:0] REQ_RESIZE  = 2'd1;
   localparam logic [1:0] REQ_RESTORE = 2'd2;
   localparam logic [1:0] REQ_RESET   = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_BASE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_CAP  = CSR_IDX_W'(1);

   // Classified request handed from the front to the back.
   typedef struct packed {
      logic [1:0]        kind;
      logic [DATA_W-1:0] size;
      logic [DATA_W-1:0] mask;
      logic              align_ok;
      logic              size_nz;
      logic              res_pre_ok;
      logic [DATA_W:0]   old_end;
      logic              new_end_fit;
      logic [DATA_W-1:0] new_end;
      logic [DATA_W-1:0] ptr;
      logic [DATA_W-1:0] mark;
   } cls_type;

   // True when v does not fit in an aw-bit address space.
   function automatic logic addr_ovf(input logic [SUM_W-1:0] v, input int unsigned aw);
      logic res;
      res = 1'b0;
      if (aw < SUM_W) begin
         res = ((v >> aw) != '0);
      end
      return res;
   endfunction

endpackage

// ----- rtl/abm_if.sv -----
`timescale 1ns / 1ps
interface abm_req_if
   import abm_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic [1:0]        req_type;
   logic [DATA_W-1:0] req_size;
   logic [DATA_W-1:0] req_align;
   logic [DATA_W-1:0] block_addr;
   logic [DATA_W-1:0] req_old_size;
   logic [DATA_W-1:0] mark_value;

   modport source (output valid, req_type, req_size, req_align, block_addr, req_old_size,
                   mark_value, input ready);
   modport sink (input valid, req_type, req_size, req_align, block_addr, req_old_size,
                 mark_value, output ready);
endinterface

interface abm_rsp_if
   import abm_pkg::*;
   ;
   logic              valid;
   logic              ready;
   logic              ok;
   logic [DATA_W-1:0] result_addr;
   logic              moved;
   logic [DATA_W-1:0] used_bytes;
   logic [DATA_W-1:0] remaining_bytes;

   modport source (output valid, ok, result_addr, moved, used_bytes, remaining_bytes,
                   input ready);
   modport sink (input valid, ok, result_addr, moved, used_bytes, remaining_bytes,
                 output ready);
endinterface

// ----- rtl/arena_bump_allocator.sv -----
`timescale 1ns / 1ps
// A request beat is classified and queued; its result is registered on pop.
// One request per cycle while results are taken; the back-end offset update
// is combinational and a two-entry queue decouples front and back.
// Reset (synchronous, active high) clears base, capacity, used offset, the
// queue and result valid flag; writing base or capacity clears the offset.
module arena_bump_allocator
   import abm_pkg::*;
#(
   parameter int ADDR_W = ADDR_W_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   abm_req_if.sink              req_chan,
   abm_rsp_if.source            rsp_chan,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wr_data
);

   logic [DATA_W-1:0] base_ff, base_in;
   logic [DATA_W-1:0] cap_ff, cap_in;
   logic              cfg_clear;
   logic [DATA_W-1:0] cap_eff;
   cls_type           cls;
   cls_type           head_data;
   logic              q_full;
   logic              head_valid;
   logic              pop;

   always_comb begin
      base_in   = base_ff;
      cap_in    = cap_ff;
      cfg_clear = 1'b0;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_BASE: begin
               base_in   = csr_wr_data;
               cfg_clear = 1'b1;
            end
            CSR_CAP: begin
               cap_in    = csr_wr_data;
               cfg_clear = 1'b1;
            end
            default: begin
               cfg_clear = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
         cap_ff  <= '0;
      end else begin
         base_ff <= base_in;
         cap_ff  <= cap_in;
      end
   end

   // No buffer means no capacity.
   assign cap_eff = (base_ff != '0) ? cap_ff : '0;

   assign req_chan.ready = !q_full;

   abm_front #(.ADDR_W(ADDR_W)) u_front (
      .req_type     (req_chan.req_type),
      .req_size     (req_chan.req_size),
      .req_align    (req_chan.req_align),
      .block_addr   (req_chan.block_addr),
      .req_old_size (req_chan.req_old_size),
      .mark_value   (req_chan.mark_value),
      .base_addr    (base_ff),
      .cap_eff      (cap_eff),
      .cls          (cls)
   );

   abm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (req_chan.valid && !q_full),
      .push_data  (cls),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   abm_back #(.ADDR_W(ADDR_W)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg_clear     (cfg_clear),
      .base_addr     (base_ff),
      .cap_eff       (cap_eff),
      .head_valid    (head_valid),
      .head_data     (head_data),
      .pop           (pop),
      .rsp_ready     (rsp_chan.ready),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ok        (rsp_chan.ok),
      .rsp_addr      (rsp_chan.result_addr),
      .rsp_moved     (rsp_chan.moved),
      .rsp_used      (rsp_chan.used_bytes),
      .rsp_remaining (rsp_chan.remaining_bytes)
   );

endmodule

// ----- rtl/abm_front.sv -----
`timescale 1ns / 1ps
module abm_front
   import abm_pkg::*;
#(
   parameter int ADDR_W = ADDR_W_DEF
) (
   input  logic [1:0]        req_type,
   input  logic [DATA_W-1:0] req_size,
   input  logic [DATA_W-1:0] req_align,
   input  logic [DATA_W-1:0] block_addr,
   input  logic [DATA_W-1:0] req_old_size,
   input  logic [DATA_W-1:0] mark_value,
   input  logic [DATA_W-1:0] base_addr,
   input  logic [DATA_W-1:0] cap_eff,
   output cls_type           cls
);

   logic [DATA_W-1:0] align_m1;
   logic [DATA_W-1:0] start;
   logic [DATA_W:0]   ptr_hi;
   logic [DATA_W:0]   old_end;
   logic [DATA_W:0]   new_end;
   logic              align_ok;
   logic              size_nz;
   logic              base_nz;
   logic              ptr_ok;

   always_comb begin
      align_m1 = req_align - DATA_W'(1);
      align_ok = (req_align != '0) && ((req_align & align_m1) == '0);
      size_nz  = (req_size != '0);
      base_nz  = (base_addr != '0);
      ptr_hi   = {1'b0, base_addr} + {1'b0, cap_eff};
      ptr_ok   = (block_addr != '0) && (block_addr >= base_addr) &&
                 ({1'b0, block_addr} <= ptr_hi);
      start    = block_addr - base_addr;
      old_end  = {1'b0, start} + {1'b0, req_old_size};
      new_end  = {1'b0, start} + {1'b0, req_size};

      cls.kind        = req_type;
      cls.size        = req_size;
      cls.mask        = align_m1;
      cls.align_ok    = align_ok;
      cls.size_nz     = size_nz;
      cls.res_pre_ok  = align_ok && ptr_ok && base_nz && size_nz &&
                        !addr_ovf(SUM_W'(old_end), ADDR_W);
      cls.old_end     = old_end;
      cls.new_end_fit = !addr_ovf(SUM_W'(new_end), ADDR_W) && (new_end <= {1'b0, cap_eff});
      cls.new_end     = new_end[DATA_W-1:0];
      cls.ptr         = block_addr;
      cls.mark        = mark_value;
   end

endmodule

// ----- rtl/abm_queue.sv -----
`timescale 1ns / 1ps
module abm_queue
   import abm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cls_type push_data,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output cls_type head_data
);

   cls_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- rtl/abm_back.sv -----
`timescale 1ns / 1ps
module abm_back
   import abm_pkg::*;
#(
   parameter int ADDR_W = ADDR_W_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cfg_clear,
   input  logic [DATA_W-1:0] base_addr,
   input  logic [DATA_W-1:0] cap_eff,
   input  logic              head_valid,
   input  cls_type           head_data,
   output logic              pop,
   input  logic              rsp_ready,
   output logic              rsp_valid,
   output logic              rsp_ok,
   output logic [DATA_W-1:0] rsp_addr,
   output logic              rsp_moved,
   output logic [DATA_W-1:0] rsp_used,
   output logic [DATA_W-1:0] rsp_remaining
);

   logic [DATA_W-1:0] offset_ff, offset_in;
   logic              valid_ff, valid_in;
   logic              ok_ff, ok_in;
   logic [DATA_W-1:0] addr_ff, addr_in;
   logic              moved_ff, moved_in;
   logic [DATA_W-1:0] used_ff, used_in;

   logic [SUM_W-1:0]  cur;
   logic [SUM_W-1:0]  cur_m;
   logic [SUM_W-1:0]  aligned;
   logic [SUM_W-1:0]  alloc_end;
   logic              alloc_ok;
   logic              in_place;

   assign pop = head_valid && (!valid_ff || rsp_ready);

   always_comb begin
      // Aligned address and end offset of a fresh allocation.
      cur       = SUM_W'(base_addr) + SUM_W'(offset_ff);
      cur_m     = cur + SUM_W'(head_data.mask);
      aligned   = cur_m & ~SUM_W'(head_data.mask);
      alloc_end = aligned - SUM_W'(base_addr) + SUM_W'(head_data.size);
      alloc_ok  = (base_addr != '0) && head_data.size_nz && head_data.align_ok &&
                  (offset_ff <= cap_eff) && !addr_ovf(cur, ADDR_W) &&
                  !addr_ovf(cur_m, ADDR_W) && !addr_ovf(alloc_end, ADDR_W) &&
                  (alloc_end <= SUM_W'(cap_eff));
      in_place  = head_data.res_pre_ok && (head_data.old_end == {1'b0, offset_ff}) &&
                  head_data.new_end_fit;

      offset_in = offset_ff;
      ok_in     = 1'b0;
      addr_in   = '0;
      moved_in  = 1'b0;
      case (head_data.kind)
         REQ_ALLOC: begin
            if (alloc_ok) begin
               ok_in     = 1'b1;
               addr_in   = aligned[DATA_W-1:0];
               offset_in = alloc_end[DATA_W-1:0];
            end
         end
         REQ_RESIZE: begin
            if (in_place) begin
               ok_in     = 1'b1;
               addr_in   = head_data.ptr;
               offset_in = head_data.new_end;
            end else if (head_data.res_pre_ok && alloc_ok) begin
               ok_in     = 1'b1;
               moved_in  = 1'b1;
               addr_in   = aligned[DATA_W-1:0];
               offset_in = alloc_end[DATA_W-1:0];
            end
         end
         REQ_RESTORE: begin
            if (head_data.mark <= offset_ff) begin
               ok_in     = 1'b1;
               offset_in = head_data.mark;
            end
         end
         REQ_RESET: begin
            ok_in     = 1'b1;
            offset_in = '0;
         end
         default: begin
            ok_in = 1'b0;
         end
      endcase
      used_in = offset_in;

      // Hold the result until taken; advance when a new beat is popped.
      valid_in = pop ? 1'b1 : (valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (cfg_clear) begin
            offset_ff <= '0;
         end else if (pop) begin
            offset_ff <= offset_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ok_ff    <= ok_in;
         addr_ff  <= addr_in;
         moved_ff <= moved_in;
         used_ff  <= used_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_ok        = ok_ff;
   assign rsp_addr      = addr_ff;
   assign rsp_moved     = moved_ff;
   assign rsp_used      = used_ff;
   assign rsp_remaining = (used_ff > cap_eff) ? '0 : (cap_eff - used_ff);

endmodule
